// ===== rtl/core/otq_pkg.sv =====
// Shared types and constants for the ordered timer queue.
// Used by every module of the block and by its checker; depends on nothing.
package otq_pkg;

  // Number of timer slots, and the most expiries reported for one beat.
  localparam int TIMERS      = 16;
  localparam int MAX_RESULTS = 16;

  // Slot index width and armed counter width.
  localparam int HW   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNTW = $clog2(TIMERS + 1);

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;

  // Request opcodes.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_ERASE  = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_BEAT   = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  handle;
    logic [31:0] time_value;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  out_handle;
    logic [31:0] out_time;
    logic [4:0]  armed_count;
    logic        last;
  } result_t;

  // Decoded command kinds, as classified by the front.
  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ERASE,
    CMD_SEARCH,
    CMD_READ,
    CMD_BEAT,
    CMD_CLEAR,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t      kind;
    logic           handle_ok;
    logic [3:0]     handle;
    logic [HW-1:0]  slot;
    logic [31:0]    time_value;
  } cmd_t;

  // Fill status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC,
    S_RANK,
    S_EMIT
  } back_state_t;

endpackage

// ===== rtl/core/otq_front.sv =====
// Front end of the ordered timer queue: accepts requests and classifies them.
// Depends on otq_pkg for the request, command and queue status types.
module otq_front (
  input  logic             start,
  input  otq_pkg::request_t request,
  input  otq_pkg::q_status_t q_stat,
  output logic             push,
  output otq_pkg::cmd_t    cmd
);
  import otq_pkg::*;

  // A request is taken whenever the queue has room.
  assign push = start && !q_stat.full;

  // Decode the opcode and check the handle range.
  always_comb begin
    cmd.handle     = request.handle;
    cmd.slot       = HW'(request.handle);
    cmd.handle_ok  = (32'(request.handle) < TIMERS);
    cmd.time_value = request.time_value;
    case (request.opcode)
      OP_INSERT: cmd.kind = CMD_INSERT;
      OP_REMOVE: cmd.kind = CMD_REMOVE;
      OP_ERASE:  cmd.kind = CMD_ERASE;
      OP_SEARCH: cmd.kind = CMD_SEARCH;
      OP_READ:   cmd.kind = CMD_READ;
      OP_BEAT:   cmd.kind = CMD_BEAT;
      OP_CLEAR:  cmd.kind = CMD_CLEAR;
      default:   cmd.kind = CMD_BAD;
    endcase
  end

endmodule

// ===== rtl/core/otq_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on otq_pkg for the command type and the queue depth.
module otq_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  otq_pkg::cmd_t      wr_cmd,
  input  logic               pop,
  output otq_pkg::cmd_t      head,
  output otq_pkg::q_status_t q_stat
);
  import otq_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] fill;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (fill == QCW'(QDEPTH));
  assign q_stat.empty = (fill == '0);

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCW'(1);
      end else if (pop && !push) begin
        fill <= fill - QCW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/otq_back.sv =====
// Back end of the ordered timer queue: timer state and command execution.
// Depends on otq_pkg for command, result, state and status definitions.
module otq_back (
  input  logic               clk,
  input  logic               rst,
  input  otq_pkg::cmd_t      head,
  input  otq_pkg::q_status_t q_stat,
  output logic               pop,
  output logic               done,
  output otq_pkg::result_t   result
);
  import otq_pkg::*;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [HW-1:0] first_set(input logic [TIMERS-1:0] vec);
    logic [HW-1:0] idx;
    idx = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (vec[i]) idx = HW'(i);
    end
    return idx;
  endfunction

  back_state_t state, state_next;

  cmd_t              cmd;
  logic [31:0]       store [TIMERS];
  logic [TIMERS-1:0] armed;
  logic [CNTW-1:0]   active;
  logic [TIMERS-1:0] match_vec;
  logic [TIMERS-1:0] exp_vec;
  logic [HW-1:0]     rank [TIMERS];
  logic [HW-1:0]     scan;
  logic [CNTW-1:0]   exp_cnt;
  logic [CNTW-1:0]   emit_pos;

  logic [TIMERS-1:0] armed_next;
  logic [CNTW-1:0]   active_next;
  logic              store_we;
  logic              done_next;
  result_t           result_next;

  logic              match_any;
  logic [HW-1:0]     match_idx;
  logic [TIMERS-1:0] sel_vec;
  logic [HW-1:0]     sel_idx;
  logic [CNTW-1:0]   emit_inc;
  logic              emit_last;
  logic [31:0]       scan_time;

  assign match_any = |match_vec;
  assign match_idx = first_set(match_vec);
  assign scan_time = store[scan];
  assign emit_inc  = emit_pos + CNTW'(1);
  assign emit_last = (emit_inc == exp_cnt) || (int'(emit_inc) == MAX_RESULTS);

  // The expired timer whose rank equals the next output position.
  always_comb begin
    for (int i = 0; i < TIMERS; i++) begin
      sel_vec[i] = exp_vec[i] && (rank[i] == emit_pos[HW-1:0]);
    end
  end
  assign sel_idx = first_set(sel_vec);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, result and timer state updates.
  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    done_next   = 1'b0;
    store_we    = 1'b0;
    armed_next  = armed;
    active_next = active;
    result_next = '0;
    case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        state_next = (cmd.kind == CMD_BEAT) ? S_RANK : S_EXEC;
      end
      S_EXEC: begin
        done_next        = 1'b1;
        result_next.last = 1'b1;
        state_next       = S_IDLE;
        case (cmd.kind)
          CMD_INSERT: begin
            result_next.out_handle = cmd.handle;
            result_next.out_time   = cmd.time_value;
            if (!cmd.handle_ok || armed[cmd.slot] || match_any) begin
              result_next.status = ST_REJECT;
            end else begin
              result_next.status     = ST_OK;
              store_we               = 1'b1;
              armed_next[cmd.slot]   = 1'b1;
              active_next            = active + CNTW'(1);
            end
          end
          CMD_REMOVE: begin
            result_next.out_handle = cmd.handle;
            if (!cmd.handle_ok || !armed[cmd.slot]) begin
              result_next.status = ST_REJECT;
            end else begin
              result_next.status   = ST_OK;
              result_next.out_time = store[cmd.slot];
              armed_next[cmd.slot] = 1'b0;
              active_next          = active - CNTW'(1);
            end
          end
          CMD_ERASE, CMD_SEARCH: begin
            result_next.out_time = cmd.time_value;
            if (!match_any) begin
              result_next.status = ST_REJECT;
            end else begin
              result_next.status     = ST_OK;
              result_next.out_handle = 4'(match_idx);
              if (cmd.kind == CMD_ERASE) begin
                armed_next[match_idx] = 1'b0;
                active_next           = active - CNTW'(1);
              end
            end
          end
          CMD_READ: begin
            result_next.out_handle = cmd.handle;
            if (!cmd.handle_ok) begin
              result_next.status = ST_REJECT;
            end else begin
              result_next.status   = ST_OK;
              result_next.out_time = store[cmd.slot];
            end
          end
          CMD_CLEAR: begin
            result_next.status = ST_OK;
            armed_next         = '0;
            active_next        = '0;
          end
          default: begin
            result_next.status = ST_REJECT;
          end
        endcase
        result_next.armed_count = 5'(active_next);
      end
      S_RANK: begin
        if (scan == HW'(TIMERS - 1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        done_next = 1'b1;
        if (exp_cnt == '0) begin
          result_next.status = ST_NONE;
          result_next.last   = 1'b1;
          state_next         = S_IDLE;
        end else begin
          result_next.status     = ST_EXPIRED;
          result_next.out_handle = 4'(sel_idx);
          result_next.out_time   = store[sel_idx];
          result_next.last       = emit_last;
          armed_next[sel_idx]    = 1'b0;
          active_next            = active - CNTW'(1);
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
        result_next.armed_count = 5'(active_next);
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers: armed flags, armed count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed  <= '0;
      active <= '0;
      done   <= 1'b0;
    end else begin
      armed  <= armed_next;
      active <= active_next;
      done   <= done_next;
    end
  end

  // Payload registers: command, expiry store, beat ranking and result.
  always_ff @(posedge clk) begin
    result <= result_next;
    if (pop) begin
      cmd <= head;
    end
    if (store_we) begin
      store[cmd.slot] <= cmd.time_value;
    end
    case (state)
      S_MATCH: begin
        // Compare every slot against the request time at once.
        for (int i = 0; i < TIMERS; i++) begin
          match_vec[i] <= armed[i] && (store[i] == cmd.time_value);
          exp_vec[i]   <= armed[i] && (store[i] <= cmd.time_value);
          rank[i]      <= '0;
        end
        scan     <= '0;
        exp_cnt  <= '0;
        emit_pos <= '0;
      end
      S_RANK: begin
        // One slot per cycle: if the slot is expired, every timer later than it moves up a rank.
        for (int i = 0; i < TIMERS; i++) begin
          if (exp_vec[scan] && (scan_time < store[i])) begin
            rank[i] <= rank[i] + HW'(1);
          end
        end
        exp_cnt <= exp_cnt + CNTW'(exp_vec[scan]);
        scan    <= scan + HW'(1);
      end
      S_EMIT: begin
        emit_pos <= emit_inc;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/ordered_timer_queue_top.sv =====
// Top level of the ordered timer queue.
// Depends on otq_pkg, otq_front, otq_queue and otq_back.
//
//   Channel  Handshake        Payload    Notes
//   request  start / busy     request    taken when start is high, busy low
//   result   done (strobe)    result     shown for one cycle, cannot be held
//
// A request that gives one result is popped from the queue, compared and then
// executed; the back end finishes one command (pop, compare, execute) before it pops the next.
// A beat is popped and compared like any other command, then ranks the expired
// timers one slot per cycle, then gives one result per cycle, at most MAX_RESULTS
// of them.
// Busy rises while the two-entry command queue is full.
// Reset clears the armed flags and count at once; there is no clearing pass.
module ordered_timer_queue_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  otq_pkg::request_t request,
  output logic              done,
  output otq_pkg::result_t  result
);
  import otq_pkg::*;

  logic      push;
  logic      pop;
  cmd_t      new_cmd;
  cmd_t      head;
  q_status_t q_stat;

  assign busy = q_stat.full;

  otq_front u_front (
    .start   (start),
    .request (request),
    .q_stat  (q_stat),
    .push    (push),
    .cmd     (new_cmd)
  );

  otq_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (new_cmd),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  otq_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

// ===== rtl/core/otq_checker.sv =====
// Port-level checks for the ordered timer queue, bound to the top level.
// Depends on otq_pkg for the result type and status codes.
module otq_checker (
  input logic              clk,
  input logic              rst,
  input logic              done,
  input otq_pkg::result_t  result
);
  import otq_pkg::*;

  // Only expiry reports can be followed by more results of the same request.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_EXPIRED) |-> result.last)
    else $error("non-expiry result without last");

  // Expiry reports of one beat come back to back.
  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last) |=> (done && result.status == ST_EXPIRED))
    else $error("beat burst broken");

  // Expiry reports come in strictly ascending time order.
  a_burst_ascending: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last) |=> (result.out_time > $past(result.out_time)))
    else $error("expiries out of order");

  // Each expiry disarms exactly one timer.
  a_burst_count: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last) |=> (result.armed_count == $past(result.armed_count) - 5'd1))
    else $error("armed count mismatch in beat");

  // The armed count never exceeds the number of slots.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.armed_count) <= TIMERS))
    else $error("armed count out of range");

endmodule

bind ordered_timer_queue_top otq_checker u_otq_checker (
  .clk     (clk),
  .rst     (rst),
  .done    (done),
  .result  (result)
);

// ===== tb/sv/ordered_timer_queue_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for ordered_timer_queue_top: directed and random timer requests,
// each result checked against a behavioral predictor of the queue kept here.
// Depends on otq_pkg and the ordered_timer_queue_top RTL.
module ordered_timer_queue_top_tb;
  import otq_pkg::*;

  // Opcode value that the block does not implement.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int RESET_CYCLES = 8;
  // Ranking pass plus the longest burst of expiries, with margin.
  localparam int DRAIN_CYCLES = 3 + TIMERS + MAX_RESULTS + 16;
  localparam int CYCLE_LIMIT  = 400000;

  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  // Predicted state of the timer slots.
  logic [31:0] slot_expiry  [TIMERS];
  logic        slot_armed   [TIMERS];
  logic        slot_written [TIMERS];
  logic [4:0]  armed_total;

  // Results that accepted requests are still owed, oldest first.
  result_t pending_results [$];

  int error_count  = 0;
  int cycle_count  = 0;
  bit sender_idles = 1'b1;

  ordered_timer_queue_top u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #10 clk = ~clk;

  // Run limit: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ordered_timer_queue_top_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
    error_count++;
  endtask

  function automatic result_t make_result(logic [1:0] st, logic [3:0] h, logic [31:0] t,
                                          logic lst);
    result_t r;
    r.status      = st;
    r.out_handle  = h;
    r.out_time    = t;
    r.armed_count = armed_total;
    r.last        = lst;
    return r;
  endfunction

  // Slot of the armed timer with the given expiry, or -1.
  function automatic int armed_slot_with(logic [31:0] t);
    for (int i = 0; i < TIMERS; i++) begin
      if (slot_armed[i] && slot_expiry[i] == t) return i;
    end
    return -1;
  endfunction

  function automatic void disarm_slot(int i);
    slot_armed[i] = 1'b0;
    if (armed_total > 0) armed_total--;
  endfunction

  // Updates the predicted slots for one request and queues the results it owes.
  task automatic compute_timer_results(request_t req);
    int         idx;
    int         earliest;
    int         fired;
    logic [3:0] h;
    result_t    tail;
    h = req.handle;
    case (req.opcode)
      OP_INSERT: begin
        if (slot_armed[h] || armed_slot_with(req.time_value) >= 0) begin
          pending_results.push_back(make_result(ST_REJECT, h, req.time_value, 1'b1));
        end else begin
          slot_expiry[h]  = req.time_value;
          slot_armed[h]   = 1'b1;
          slot_written[h] = 1'b1;
          armed_total++;
          pending_results.push_back(make_result(ST_OK, h, req.time_value, 1'b1));
        end
      end
      OP_REMOVE: begin
        if (!slot_armed[h]) begin
          pending_results.push_back(make_result(ST_REJECT, h, 32'd0, 1'b1));
        end else begin
          disarm_slot(int'(h));
          pending_results.push_back(make_result(ST_OK, h, slot_expiry[h], 1'b1));
        end
      end
      OP_ERASE, OP_SEARCH: begin
        idx = armed_slot_with(req.time_value);
        if (idx < 0) begin
          pending_results.push_back(make_result(ST_REJECT, 4'd0, req.time_value, 1'b1));
        end else begin
          if (req.opcode == OP_ERASE) disarm_slot(idx);
          pending_results.push_back(make_result(ST_OK, 4'(idx), req.time_value, 1'b1));
        end
      end
      OP_READ: begin
        pending_results.push_back(make_result(ST_OK, h, slot_expiry[h], 1'b1));
      end
      OP_BEAT: begin
        // Expired timers come out earliest first, up to the per-beat cap.
        fired = 0;
        while (fired < MAX_RESULTS) begin
          earliest = -1;
          for (int i = 0; i < TIMERS; i++) begin
            if (slot_armed[i] && slot_expiry[i] <= req.time_value &&
                (earliest < 0 || slot_expiry[i] < slot_expiry[earliest]))
              earliest = i;
          end
          if (earliest < 0) break;
          disarm_slot(earliest);
          pending_results.push_back(make_result(ST_EXPIRED, 4'(earliest),
                                                slot_expiry[earliest], 1'b0));
          fired++;
        end
        if (fired == 0) begin
          pending_results.push_back(make_result(ST_NONE, 4'd0, 32'd0, 1'b1));
        end else begin
          tail = pending_results.pop_back();
          tail.last = 1'b1;
          pending_results.push_back(tail);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < TIMERS; i++) slot_armed[i] = 1'b0;
        armed_total = '0;
        pending_results.push_back(make_result(ST_OK, 4'd0, 32'd0, 1'b1));
      end
      default: begin
        pending_results.push_back(make_result(ST_REJECT, 4'd0, 32'd0, 1'b1));
      end
    endcase
  endtask

  // Offers one request, waits until it is taken, then, while sender_idles is set, idles for a random gap.
  task automatic send_request(logic [2:0] op, logic [3:0] h, logic [31:0] t);
    request_t req;
    int       gap;
    req.opcode     = op;
    req.handle     = h;
    req.time_value = t;
    request <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    compute_timer_results(req);
    gap = sender_idles ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds requests off until every owed result has arrived and the block settles.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Expiry or current time: extremes, an armed expiry, or any value.
  function automatic logic [31:0] pick_time();
    int armed_idx [$];
    for (int i = 0; i < TIMERS; i++) begin
      if (slot_armed[i]) armed_idx.push_back(i);
    end
    case ($urandom_range(0, 7))
      0: return 32'(($urandom_range(0, 15)));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      2, 3: begin
        if (armed_idx.size() != 0)
          return slot_expiry[armed_idx[$urandom_range(0, armed_idx.size() - 1)]];
      end
      default: ;
    endcase
    return $urandom();
  endfunction

  // A handle whose expiry has been stored at least once, or -1.
  function automatic int pick_written_handle();
    int written_idx [$];
    for (int i = 0; i < TIMERS; i++) begin
      if (slot_written[i]) written_idx.push_back(i);
    end
    if (written_idx.size() == 0) return -1;
    return written_idx[$urandom_range(0, written_idx.size() - 1)];
  endfunction

  // Insert accepts a free handle and rejects a busy handle or a taken expiry.
  task automatic test_insert_rules();
    send_request(OP_INSERT, 4'd0,  32'h0000_0000);
    send_request(OP_INSERT, 4'd15, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 4'd0,  32'h0000_0005);
    send_request(OP_INSERT, 4'd7,  32'hFFFF_FFFF);
    send_request(OP_INSERT, 4'd7,  32'h8000_0000);
  endtask

  // Search, erase and read, found and not found, armed and disarmed.
  task automatic test_lookup();
    send_request(OP_SEARCH, 4'd9,  32'h0000_0000);
    send_request(OP_SEARCH, 4'd0,  32'h1234_5678);
    send_request(OP_READ,   4'd15, 32'hFFFF_FFFF);
    send_request(OP_READ,   4'd7,  32'h0000_0000);
    send_request(OP_ERASE,  4'd3,  32'hFFFF_FFFF);
    send_request(OP_ERASE,  4'd0,  32'hFFFF_FFFF);
    send_request(OP_READ,   4'd15, 32'h0000_0000);
  endtask

  // Remove of an armed handle, then of the same handle and of a never armed one.
  task automatic test_remove();
    send_request(OP_REMOVE, 4'd0, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 4'd0, 32'h0000_0000);
    send_request(OP_REMOVE, 4'd3, 32'h0000_0000);
  endtask

  // Beats with nothing due and with several due, clear, and an unused opcode.
  task automatic test_beat_and_clear();
    send_request(OP_BEAT,   4'd0,  32'h0000_0000);
    send_request(OP_INSERT, 4'd3,  32'h0000_0001);
    send_request(OP_INSERT, 4'd9,  32'h0000_0000);
    send_request(OP_BEAT,   4'd15, 32'h7FFF_FFFF);
    send_request(OP_BEAT,   4'd0,  32'hFFFF_FFFF);
    send_request(OP_INSERT, 4'd1,  32'h0000_000A);
    send_request(OP_CLEAR,  4'd15, 32'hFFFF_FFFF);
    send_request(OP_BEAT,   4'd0,  32'hFFFF_FFFF);
    send_request(OP_UNUSED, 4'd15, 32'hFFFF_FFFF);
  endtask

  // Fills every slot, tries one more insert, then beats at a picked time and then fires all that are left.
  task automatic test_full_beat();
    int offset;
    offset = $urandom_range(0, TIMERS - 1);
    send_request(OP_CLEAR, 4'($urandom_range(0, 15)), $urandom());
    for (int i = 0; i < TIMERS; i++) begin
      send_request(OP_INSERT, 4'((i + offset) % TIMERS), $urandom());
    end
    send_request(OP_INSERT, 4'($urandom_range(0, 15)), $urandom());
    send_request(OP_BEAT, 4'($urandom_range(0, 15)), pick_time());
    send_request(OP_BEAT, 4'($urandom_range(0, 15)), 32'hFFFF_FFFF);
  endtask

  // Mixed traffic with random content, in stretches with and without idling.
  task automatic test_random_traffic(int count);
    int sel;
    int h;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) sender_idles = ($urandom_range(0, 2) != 0);
      if (n == count / 2) drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        send_request(OP_INSERT, 4'($urandom_range(0, 15)), pick_time());
      end else if (sel < 50) begin
        send_request(OP_BEAT, 4'($urandom_range(0, 15)), pick_time());
      end else if (sel < 60) begin
        send_request(OP_REMOVE, 4'($urandom_range(0, 15)), $urandom());
      end else if (sel < 68) begin
        send_request(OP_ERASE, 4'($urandom_range(0, 15)), pick_time());
      end else if (sel < 76) begin
        send_request(OP_SEARCH, 4'($urandom_range(0, 15)), pick_time());
      end else if (sel < 88) begin
        h = pick_written_handle();
        if (h < 0) send_request(OP_INSERT, 4'($urandom_range(0, 15)), pick_time());
        else send_request(OP_READ, 4'(h), $urandom());
      end else if (sel < 93) begin
        send_request(OP_CLEAR, 4'($urandom_range(0, 15)), $urandom());
      end else begin
        send_request(OP_UNUSED, 4'($urandom_range(0, 15)), $urandom());
      end
    end
  endtask

  // Compares each result with the oldest one owed.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request owed", 32'd0, result.out_time);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(result.status));
        if (result.out_handle !== want.out_handle)
          report_mismatch("out_handle", 32'(want.out_handle), 32'(result.out_handle));
        if (result.out_time !== want.out_time)
          report_mismatch("out_time", want.out_time, result.out_time);
        if (result.armed_count !== want.armed_count)
          report_mismatch("armed_count", 32'(want.armed_count),
                          32'(result.armed_count));
        if (result.last !== want.last)
          report_mismatch("last", 32'(want.last), 32'(result.last));
      end
    end
  end

  initial begin
    for (int i = 0; i < TIMERS; i++) begin
      slot_expiry[i]  = '0;
      slot_armed[i]   = 1'b0;
      slot_written[i] = 1'b0;
    end
    armed_total = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_insert_rules();
    test_lookup();
    test_remove();
    test_beat_and_clear();
    test_full_beat();
    test_random_traffic(95);
    test_full_beat();
    test_random_traffic(95);
    test_full_beat();

    drain_results();
    if (error_count == 0) begin
      $display("ordered_timer_queue_top_tb: done, clean");
    end else begin
      $display("ordered_timer_queue_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== ordered_timer_queue_top.f =====
rtl/core/otq_pkg.sv
rtl/core/otq_front.sv
rtl/core/otq_queue.sv
rtl/core/otq_back.sv
rtl/core/ordered_timer_queue_top.sv
rtl/core/otq_checker.sv
tb/sv/ordered_timer_queue_top_tb.sv
